// ===== rtl/ssd_pkg.sv =====
// Shared types, constants and the digit-to-segment function for the
// seven-segment serializer. No dependencies.
`default_nettype none

package ssd_pkg;

	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned MASK_W      = 4;
	localparam int unsigned SEG_W       = 8;
	localparam int unsigned SEG_DP_BIT  = 7;

	// Quotient by ten as (x * RECIP_10) >> RECIP_SHIFT, exact for x < 43699.
	localparam int unsigned RECIP_10    = 52429;
	localparam int unsigned RECIP_W     = 16;
	localparam int unsigned RECIP_SHIFT = 19;

	typedef logic [3:0]       bcd_t;
	typedef logic [SEG_W-1:0] seg_t;

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// Active-low common-anode patterns; segment a is bit 0, the point is bit 7.
	function automatic seg_t seg_pattern(input bcd_t d);
		seg_t s;
		unique case (d)
			4'd0:    s = 8'hC0;
			4'd1:    s = 8'hF9;
			4'd2:    s = 8'hA4;
			4'd3:    s = 8'hB0;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h92;
			4'd6:    s = 8'h82;
			4'd7:    s = 8'hF8;
			4'd8:    s = 8'h80;
			4'd9:    s = 8'h90;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ssd_if.sv =====
// Request channels of the serializer: the number going in and the serial bits
// coming out. Depends on ssd_pkg for the value width.
`default_nettype none

interface ssd_value_if;
	logic                         valid;
	logic                         ready;
	logic [ssd_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface ssd_bit_if;
	logic valid;
	logic ready;
	logic serial_bit;
	logic latch_strobe;

	modport source (output valid, output serial_bit, output latch_strobe, input ready);
	modport sink   (input valid, input serial_bit, input latch_strobe, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssd_encode.sv =====
// Encoding pipeline: saturation, one decimal digit per stage, and the
// segment pattern stage. Depends on ssd_pkg and ssd_if.
`default_nettype none

module ssd_encode #(
	parameter int unsigned DIGITS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ssd_value_if.sink                        value_ch,
	input  wire logic [ssd_pkg::MASK_W-1:0]  point_mask,
	output logic                             pat_valid,
	input  wire logic                        pat_ready,
	output logic [8*DIGITS-1:0]              pattern
);
	import ssd_pkg::*;

	localparam int unsigned LIMIT = pow10(DIGITS) - 1;
	localparam int unsigned VW    = $clog2(LIMIT + 1);
	localparam int unsigned PW    = VW + RECIP_W;

	typedef bcd_t digits_t [DIGITS];

	logic          adv;

	logic          valid_s1;
	logic [VW-1:0] value_s1;

	logic          valid_s2  [DIGITS];
	logic [VW-1:0] quot_s2   [DIGITS];
	digits_t       digits_s2 [DIGITS];

	logic          in_valid  [DIGITS];
	logic [VW-1:0] in_quot   [DIGITS];
	digits_t       in_digits [DIGITS];

	logic                valid_s3;
	logic [8*DIGITS-1:0] pattern_s3;

	// The whole pipe moves together; it holds only while the pattern waits.
	assign adv            = !valid_s3 || pat_ready;
	assign value_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (value_ch.value > VALUE_W'(LIMIT)) begin
				value_s1 <= VW'(LIMIT);
			end else begin
				value_s1 <= value_ch.value[VW-1:0];
			end
		end
	end

	for (genvar k = 0; k < DIGITS; k++) begin : g_digit
		logic [PW-1:0] prod;
		logic [VW-1:0] quot;
		logic [VW-1:0] tens;
		digits_t       next_digits;

		if (k == 0) begin : g_first
			always_comb begin
				in_valid[k]  = valid_s1;
				in_quot[k]   = value_s1;
				in_digits[k] = '{default: '0};
			end
		end else begin : g_next
			always_comb begin
				in_valid[k]  = valid_s2[k-1];
				in_quot[k]   = quot_s2[k-1];
				in_digits[k] = digits_s2[k-1];
			end
		end

		assign prod = PW'(in_quot[k]) * PW'(RECIP_10);
		assign quot = VW'(prod >> RECIP_SHIFT);
		assign tens = VW'({quot, 3'b000}) + VW'({quot, 1'b0});

		always_comb begin
			next_digits    = in_digits[k];
			next_digits[k] = bcd_t'(in_quot[k] - tens);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[k] <= 1'b0;
			end else if (adv) begin
				valid_s2[k] <= in_valid[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quot_s2[k]   <= quot;
				digits_s2[k] <= next_digits;
			end
		end
	end

	// Units byte lands in the top byte so that it leaves the shifter first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2[DIGITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIGITS; k++) begin
				pattern_s3[SEG_W*(DIGITS-1-k) +: SEG_W] <=
					seg_pattern(digits_s2[DIGITS-1][k]) &
					~(seg_t'(point_mask[k]) << SEG_DP_BIT);
			end
		end
	end

	assign pat_valid = valid_s3;
	assign pattern   = pattern_s3;

endmodule

`default_nettype wire

// ===== rtl/four_digit_seven_segment_serializer_core.sv =====
// Top level of the seven-segment serializer: decimal point mask register,
// encoding pipeline and output shift register. Depends on ssd_pkg, ssd_if
// and ssd_encode.
// A value passes the saturation, digit and pattern stages and the output shift
// register before its first serial bit is valid; its 8*DIGITS bits then follow
// one per cycle while bit_ch.ready is high; the single output shifter paces values.
// Reset clears all valid bits and the bit counter and sets the point mask to 2.
`default_nettype none

module four_digit_seven_segment_serializer_core #(
	parameter int unsigned DIGITS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ssd_value_if.sink                        value_ch,
	ssd_bit_if.source                        bit_ch,
	input  wire logic                        cfg_we,
	input  wire logic [ssd_pkg::MASK_W-1:0]  cfg_wdata
);
	import ssd_pkg::*;

	localparam int unsigned NBITS = 8 * DIGITS;
	localparam int unsigned CW    = $clog2(NBITS + 1);

	logic [MASK_W-1:0] point_mask_q;
	logic              pat_valid;
	logic              pat_ready;
	logic [NBITS-1:0]  pattern;
	logic [NBITS-1:0]  shift_q;
	logic [CW-1:0]     bits_left_q;
	logic              out_take;
	logic              load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_mask_q <= MASK_W'(2);
		end else if (cfg_we) begin
			point_mask_q <= cfg_wdata;
		end
	end

	ssd_encode #(
		.DIGITS (DIGITS)
	) u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_ch   (value_ch),
		.point_mask (point_mask_q),
		.pat_valid  (pat_valid),
		.pat_ready  (pat_ready),
		.pattern    (pattern)
	);

	// A new pattern loads when the shifter is empty or its last bit is taken now.
	assign out_take  = bit_ch.valid && bit_ch.ready;
	assign pat_ready = (bits_left_q == '0) || ((bits_left_q == CW'(1)) && bit_ch.ready);
	assign load      = pat_valid && pat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
		end else if (load) begin
			bits_left_q <= CW'(NBITS);
		end else if (out_take) begin
			bits_left_q <= bits_left_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= pattern;
		end else if (out_take) begin
			shift_q <= {shift_q[NBITS-2:0], 1'b0};
		end
	end

	assign bit_ch.valid        = (bits_left_q != '0);
	assign bit_ch.serial_bit   = shift_q[NBITS-1];
	assign bit_ch.latch_strobe = (bits_left_q == CW'(1));

endmodule

`default_nettype wire
